// ----- rtl/core/mhpq_pkg.sv -----
//------------------------------------------------------------------------------
// mhpq_pkg
// Shared modes, status codes and payload types of the max-heap queue.
//------------------------------------------------------------------------------
`default_nettype none
package mhpq_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_EXTRACT  = 3'd1,
    MODE_PEEK     = 3'd2,
    MODE_INCREASE = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_SMALLER = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [9:0]         index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [10:0]        count;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/mhpq_req_if.sv -----
//------------------------------------------------------------------------------
// mhpq_req_if
// Valid/ready channel carrying one request word.
//------------------------------------------------------------------------------
`default_nettype none
interface mhpq_req_if;
  logic               valid;
  logic               ready;
  mhpq_pkg::req_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mhpq_rsp_if.sv -----
//------------------------------------------------------------------------------
// mhpq_rsp_if
// Valid/ready channel carrying one result word.
//------------------------------------------------------------------------------
`default_nettype none
interface mhpq_rsp_if;
  logic               valid;
  logic               ready;
  mhpq_pkg::rsp_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/max_heap_priority_queue.sv -----
//------------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys held in one synchronous memory.
//------------------------------------------------------------------------------
// channel | dir | words
// in      | in  | mode, key, index
// out     | out | value, status, count
//
// One request at a time on the single memory port (reads registered). Sift up
// reads the parent and compares at each level, sift down reads the left child,
// then the right child, then compares; extract and delete first read the last
// entry, peek and flagged requests go straight from decode to the output.
// Reset clears the count and the control; the store is not cleared. While a
// result waits on out_ready the block takes and works the next request, then
// holds in its output state until the result register frees.
//------------------------------------------------------------------------------
`default_nettype none
module max_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mhpq_req_if.sink  in_ch,
  mhpq_rsp_if.source out_ch
);
  import mhpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD0   = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_URD   = 10'b0000001000,
    S_UCMP  = 10'b0000010000,
    S_DRDL  = 10'b0000100000,
    S_DRDR  = 10'b0001000000,
    S_DCMP  = 10'b0010000000,
    S_MOVE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  // storage
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  req_t               req_r, req_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;    // current slot of the moving key
  logic signed [31:0] cur_r, cur_nxt;    // moving key
  logic signed [31:0] lkey_r, lkey_nxt;  // left child key
  logic               hasr_r, hasr_nxt;
  rsp_t               res_r, res_nxt;    // result being built
  rsp_t               rsp_r, rsp_nxt;    // result on the output
  logic               ovld_r, ovld_nxt;

  // index helpers, widened to dodge overflow
  logic [AW:0]   par, lch, rch;
  logic [AW+1:0] lch_w;
  assign par   = ({1'b0, pos_r} - 1'b1) >> 1;
  assign lch_w = {1'b0, pos_r, 1'b1};
  assign lch   = lch_w[AW:0];
  assign rch   = lch + 1'b1;

  logic idx_bad;
  assign idx_bad = ({{(CW > 10 ? CW-10 : 0){1'b0}}, req_r.index} >= count_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = rsp_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; req_nxt = req_r; pos_nxt = pos_r;
    cur_nxt = cur_r; lkey_nxt = lkey_r; hasr_nxt = hasr_r; rsp_nxt = rsp_r;
    res_nxt = res_r; ovld_nxt = ovld_r;
    we = 1'b0; waddr = pos_r; wdata = cur_r; raddr = pos_r;
    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          req_nxt = in_ch.data;
          res_nxt = '0;
          state_nxt = S_DEC;
          // read last entry for extract/delete, slot 0 for peek, index for increase
          unique case (in_ch.data.mode)
            MODE_EXTRACT, MODE_DELETE: begin
              raddr = AW'(count_r - 1'b1);
              state_nxt = S_RD0;
            end
            MODE_INCREASE: raddr = AW'(in_ch.data.index);
            default:       raddr = '0;
          endcase
        end
      end
      // grab last entry, then issue read of slot 0 for extract
      S_RD0: begin
        cur_nxt = rdata;
        raddr = '0;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        res_nxt.count = 11'(count_r);
        state_nxt = S_OUT;
        unique case (req_r.mode)
          MODE_INSERT: begin
            if (count_r >= CW'(CAPACITY)) res_nxt.status = ST_FULL;
            else begin
              count_nxt = count_r + 1'b1;
              res_nxt.count = 11'(count_r + 1'b1);
              cur_nxt = req_r.key;
              pos_nxt = AW'(count_r);
              state_nxt = S_URD;
            end
          end
          MODE_PEEK: begin
            if (count_r == '0) res_nxt.status = ST_EMPTY;
            else res_nxt.value = rdata;
          end
          MODE_EXTRACT: begin
            if (count_r == '0) res_nxt.status = ST_EMPTY;
            else begin
              res_nxt.value = rdata;
              count_nxt = count_r - 1'b1;
              res_nxt.count = 11'(count_r - 1'b1);
              pos_nxt = '0;
              state_nxt = S_DRDL;
            end
          end
          MODE_INCREASE: begin
            if (idx_bad) res_nxt.status = ST_RANGE;
            else if (req_r.key < rdata) res_nxt.status = ST_SMALLER;
            else begin
              cur_nxt = req_r.key;
              pos_nxt = AW'(req_r.index);
              state_nxt = S_URD;
            end
          end
          MODE_DELETE: begin
            if (idx_bad) res_nxt.status = ST_RANGE;
            else begin
              count_nxt = count_r - 1'b1;
              res_nxt.count = 11'(count_r - 1'b1);
              pos_nxt = AW'(req_r.index);
              if ({{(CW > 10 ? CW-10 : 0){1'b0}}, req_r.index} < CW'(count_r - 1'b1))
                state_nxt = S_URD;
            end
          end
          default: ;
        endcase
      end
      // sift up: read parent of pos
      S_URD: begin
        if (pos_r == '0) begin
          state_nxt = (req_r.mode == MODE_DELETE) ? S_DRDL : S_MOVE;
        end else begin
          raddr = par[AW-1:0];
          state_nxt = S_UCMP;
        end
      end
      S_UCMP: begin
        if (rdata < cur_r) begin
          we = 1'b1; waddr = pos_r; wdata = rdata;
          pos_nxt = par[AW-1:0];
          req_nxt.mode = MODE_INSERT;  // once moved up, never sift down
          state_nxt = S_URD;
        end else
          state_nxt = (req_r.mode == MODE_DELETE) ? S_DRDL : S_MOVE;
      end
      // sift down: read children
      S_DRDL: begin
        if ({{(CW-AW-1 > 0 ? CW-AW-1 : 0){1'b0}}, lch} >= CW'(count_r)) state_nxt = S_MOVE;
        else begin
          raddr = lch[AW-1:0];
          hasr_nxt = ({{(CW-AW-1 > 0 ? CW-AW-1 : 0){1'b0}}, rch} < CW'(count_r));
          state_nxt = S_DRDR;
        end
      end
      S_DRDR: begin
        lkey_nxt = rdata;
        raddr = rch[AW-1:0];
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if (hasr_r && (lkey_r < rdata) && (cur_r < rdata)) begin
          we = 1'b1; wdata = rdata;
          pos_nxt = rch[AW-1:0];
          state_nxt = S_DRDL;
        end else if (cur_r < lkey_r) begin
          we = 1'b1; wdata = lkey_r;
          pos_nxt = lch[AW-1:0];
          state_nxt = S_DRDL;
        end else state_nxt = S_MOVE;
      end
      S_MOVE: begin
        we = 1'b1;
        state_nxt = S_OUT;
      end
      // load the output register once it is free or being taken
      S_OUT: begin
        if (!ovld_r || out_ch.ready) begin
          rsp_nxt = res_r;
          ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
    req_r  <= req_nxt;
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    lkey_r <= lkey_nxt;
    hasr_r <= hasr_nxt;
    res_r  <= res_nxt;
    rsp_r  <= rsp_nxt;
  end

endmodule
`default_nettype wire

// ----- verif/tb_max_heap_priority_queue.sv -----
//------------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap queue: a behavioral heap predicts
// value, status and count of every request; results are compared in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int CAP = 1024;

  logic clk;
  logic rst_n;

  mhpq_req_if in_ch ();
  mhpq_rsp_if out_ch ();

  max_heap_priority_queue #(.CAPACITY(CAP)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow heap
  logic signed [31:0] shadow_heap [CAP];
  int unsigned        shadow_count;
  rsp_t               expected_rsps [$];

  int  error_count;
  int  checked_count;
  int  sent_count;
  bit  hold_off;
  bit  quiet_sink;
  bit  quiet_source;
  int  status_seen [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, checked_count);
  endtask

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void sift_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(shadow_heap[p] < shadow_heap[i])) break;
      swap_slots(p, i);
      i = p;
    end
  endfunction

  function automatic void sift_down(int unsigned i);
    int unsigned l, r, big;
    while (i < shadow_count) begin
      l = 2 * i + 1;
      r = l + 1;
      big = i;
      if (l < shadow_count && shadow_heap[big] < shadow_heap[l]) big = l;
      if (r < shadow_count && shadow_heap[big] < shadow_heap[r]) big = r;
      if (big == i) break;
      swap_slots(i, big);
      i = big;
    end
  endfunction

  // Apply one request to the shadow heap and return the expected result.
  function automatic rsp_t heap_apply(req_t rq);
    rsp_t rs;
    rs.value  = '0;
    rs.status = ST_OK;
    case (rq.mode)
      MODE_INSERT: begin
        if (shadow_count >= CAP) rs.status = ST_FULL;
        else begin
          shadow_heap[shadow_count] = rq.key;
          shadow_count++;
          sift_up(shadow_count - 1);
        end
      end
      MODE_EXTRACT: begin
        if (shadow_count == 0) rs.status = ST_EMPTY;
        else begin
          rs.value = shadow_heap[0];
          shadow_count--;
          shadow_heap[0] = shadow_heap[shadow_count];
          sift_down(0);
        end
      end
      MODE_PEEK: begin
        if (shadow_count == 0) rs.status = ST_EMPTY;
        else rs.value = shadow_heap[0];
      end
      MODE_INCREASE: begin
        if (rq.index >= shadow_count) rs.status = ST_RANGE;
        else if (rq.key < shadow_heap[rq.index]) rs.status = ST_SMALLER;
        else begin
          shadow_heap[rq.index] = rq.key;
          sift_up(rq.index);
        end
      end
      MODE_DELETE: begin
        if (rq.index >= shadow_count) rs.status = ST_RANGE;
        else begin
          shadow_count--;
          if (rq.index < shadow_count) begin
            shadow_heap[rq.index] = shadow_heap[shadow_count];
            if (rq.index > 0 && shadow_heap[(rq.index - 1) / 2] < shadow_heap[rq.index])
              sift_up(rq.index);
            else
              sift_down(rq.index);
          end
        end
      end
      default: ;
    endcase
    rs.count = shadow_count[10:0];
    return rs;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Send one request word and queue its expected result.
  task automatic send_word(input logic [2:0] mode, input logic [31:0] key,
                           input logic [9:0] index);
    req_t rq;
    int   g;
    rq.mode  = mode;
    rq.key   = key;
    rq.index = index;
    g = quiet_source ? 0 : gap_len();
    // valid drops between words
    repeat (g + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rsps.push_back(heap_apply(rq));
    sent_count++;
    in_ch.valid <= 1'b0;
  endtask

  // Result checker and sink stall
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        rsp_t got, want;
        got = out_ch.data;
        if (expected_rsps.size() == 0) begin
          error_count++;
          $display("MISMATCH unexpected result word %0h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
          status_seen[want.status]++;
        end
        checked_count++;
      end
      if (hold_off) out_ch.ready <= 1'b0;
      else if (quiet_sink) out_ch.ready <= 1'b1;
      else out_ch.ready <= (gap_len() == 0);
    end
  end

  // Directed: extremes, empty, range and smaller cases and unused modes on a small heap.
  task automatic test_directed();
    send_word(MODE_EXTRACT, 32'h0, 10'd0);
    send_word(MODE_PEEK, 32'h0, 10'd0);
    send_word(MODE_INCREASE, 32'h5, 10'd0);
    send_word(MODE_DELETE, 32'h0, 10'd1023);
    send_word(MODE_INSERT, 32'h8000_0000, 10'd0);
    send_word(MODE_INSERT, 32'h7FFF_FFFF, 10'h3FF);
    send_word(MODE_INSERT, 32'h0, 10'd0);
    send_word(MODE_INSERT, 32'hFFFF_FFFF, 10'd0);
    send_word(MODE_INSERT, 32'h1, 10'd0);
    send_word(MODE_PEEK, 32'h0, 10'd0);
    send_word(MODE_INCREASE, 32'h8000_0000, 10'd2);
    send_word(MODE_INCREASE, shadow_heap[3], 10'd3);
    send_word(MODE_INCREASE, 32'h7FFF_FFFF, 10'd4);
    send_word(MODE_INCREASE, 32'h0, 10'd5);
    send_word(3'd5, 32'hFFFF_FFFF, 10'h3FF);
    send_word(3'd6, 32'h0, 10'd0);
    send_word(3'd7, 32'h1234_5678, 10'd1);
    send_word(MODE_DELETE, 32'h0, 10'd4);
    send_word(MODE_DELETE, 32'h0, 10'd1);
    send_word(MODE_DELETE, 32'h0, 10'd5);
    send_word(MODE_EXTRACT, 32'h0, 10'd0);
    send_word(MODE_DELETE, 32'h0, 10'd0);
    while (shadow_count > 0) send_word(MODE_EXTRACT, 32'h0, 10'd0);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [9:0] rand_index();
    if (shadow_count > 0 && $urandom_range(0, 9) < 8)
      return 10'($urandom_range(0, shadow_count - 1));
    return 10'($urandom());
  endfunction

  // Random mix of all modes; mode weights drift to grow and drain the heap.
  task automatic test_random(input int n, input int grow_pct);
    logic [2:0]  m;
    logic [31:0] k;
    logic [9:0]  ix;
    int          roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) m = MODE_INSERT;
      else if (roll < grow_pct + 15) m = MODE_EXTRACT;
      else if (roll < grow_pct + 25) m = MODE_PEEK;
      else if (roll < grow_pct + 40) m = MODE_INCREASE;
      else if (roll < 97) m = MODE_DELETE;
      else m = 3'($urandom_range(5, 7));
      ix = rand_index();
      k  = rand_key();
      // increase: usually bump the current key upward
      if (m == MODE_INCREASE && ix < shadow_count && $urandom_range(0, 3) != 0)
        k = (shadow_heap[ix] < 0 || $urandom_range(0, 1)) ?
            shadow_heap[ix] + $urandom_range(0, 1000) : shadow_heap[ix];
      send_word(m, k, ix);
    end
  endtask

  // Insert under a long sink hold-off, fill to capacity, hit full, then drain part way.
  task automatic test_fill_and_stall();
    quiet_source = 1'b1;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_word(MODE_INSERT, rand_key(), 10'd0);
    join
    quiet_sink = 1'b1;
    while (shadow_count < CAP) send_word(MODE_INSERT, rand_key(), 10'd0);
    send_word(MODE_INSERT, 32'h7FFF_FFFF, 10'd0);
    send_word(MODE_PEEK, 32'h0, 10'd0);
    send_word(MODE_DELETE, 32'h0, 10'd1023);
    send_word(MODE_INCREASE, 32'h7FFF_FFFF, 10'd1022);
    repeat (40) send_word(MODE_EXTRACT, 32'h0, 10'd0);
    quiet_sink = 1'b0;
    quiet_source = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150, 55);
    test_random(100, 25);
    test_random(150, 45);
    test_fill_and_stall();
    test_random(100, 20);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests (incl. a fill to capacity), checked %0d results.",
             sent_count, checked_count);
    $display("Status mix: ok %0d empty %0d full %0d range %0d smaller %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (error_count == 0)
      $display("max_heap_priority_queue regression: pass");
    else
      $display("max_heap_priority_queue regression: fail");
    $finish;
  end

  initial begin
    #(20ns * 2_000_000);
    $display("max_heap_priority_queue regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_req_if.sv
rtl/core/mhpq_rsp_if.sv
rtl/core/max_heap_priority_queue.sv
verif/tb_max_heap_priority_queue.sv
